@@ hw/rtl/hrhp_pkg.sv @@
// hrhp_pkg: types and constants shared by the response header parser
// depends on nothing; used by hrhp_step and http_response_header_parser_top
`timescale 1ns / 1ps

package hrhp_pkg;

    typedef enum logic [2:0] {
        PH_VERSION  = 3'd0,
        PH_DIGITS   = 3'd1,
        PH_CLASSIFY = 3'd2,
        PH_HEADERS  = 3'd3,
        PH_BODY     = 3'd4,
        PH_DISCARD  = 3'd5
    } t_phase;

    localparam logic [1:0] CLS_HEADER = 2'd0;
    localparam logic [1:0] CLS_BODY   = 2'd1;
    localparam logic [1:0] CLS_DROP   = 2'd2;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_NOTFOUND = 3'd1;
    localparam logic [2:0] EV_MOVED    = 3'd2;
    localparam logic [2:0] EV_OTHER    = 3'd3;
    localparam logic [2:0] EV_HDRDONE  = 3'd4;

    localparam logic [23:0] CODE_404 = 24'h343034;
    localparam logic [23:0] CODE_301 = 24'h333031;
    localparam logic [23:0] CODE_302 = 24'h333032;
    localparam logic [23:0] CODE_200 = 24'h323030;

    localparam logic [7:0] CHAR_SP = 8'h20;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  digit_count;
        logic [23:0] status_chars;
        logic [2:0]  blank_match;
    } t_parse_state;

    typedef struct packed {
        logic [1:0] byte_class;
        logic [7:0] data_byte;
        logic [2:0] status_event;
    } t_result;

    localparam t_parse_state STATE_RESET = '{
        phase:        PH_VERSION,
        digit_count:  2'd0,
        status_chars: 24'd0,
        blank_match:  3'd0
    };

endpackage

@@ hw/rtl/hrhp_step.sv @@
// hrhp_step: next parser state and result for one received byte
// depends on hrhp_pkg
`timescale 1ns / 1ps

module hrhp_step (
    input  hrhp_pkg::t_parse_state i_state,
    input  logic [7:0]             i_byte,
    input  logic                   i_start,
    output hrhp_pkg::t_parse_state o_state,
    output hrhp_pkg::t_result      o_result
);

    hrhp_pkg::t_parse_state cur;
    logic [7:0]             expect_char;
    logic [2:0]             match_inc;

    always_comb begin
        cur = i_start ? hrhp_pkg::STATE_RESET : i_state;
        // blank line sequence alternates cr, lf
        expect_char = cur.blank_match[0] ? hrhp_pkg::CHAR_LF : hrhp_pkg::CHAR_CR;
        match_inc   = cur.blank_match + 3'd1;

        o_state  = cur;
        o_result = '{byte_class: hrhp_pkg::CLS_HEADER, data_byte: 8'd0,
                     status_event: hrhp_pkg::EV_NONE};

        unique case (cur.phase)
            hrhp_pkg::PH_VERSION: begin
                if (i_byte == hrhp_pkg::CHAR_SP) begin
                    o_state.phase = hrhp_pkg::PH_DIGITS;
                end
            end
            hrhp_pkg::PH_DIGITS: begin
                o_state.status_chars = {cur.status_chars[15:0], i_byte};
                if (cur.digit_count >= 2'd2) begin
                    o_state.digit_count = 2'd0;
                    o_state.phase       = hrhp_pkg::PH_CLASSIFY;
                end else begin
                    o_state.digit_count = cur.digit_count + 2'd1;
                end
            end
            hrhp_pkg::PH_CLASSIFY: begin
                if (cur.status_chars == hrhp_pkg::CODE_200) begin
                    o_state.phase       = hrhp_pkg::PH_HEADERS;
                    o_state.blank_match = 3'd0;
                end else begin
                    o_result.byte_class = hrhp_pkg::CLS_DROP;
                    o_state.phase       = hrhp_pkg::PH_DISCARD;
                    priority if (cur.status_chars == hrhp_pkg::CODE_404) begin
                        o_result.status_event = hrhp_pkg::EV_NOTFOUND;
                    end else if (cur.status_chars == hrhp_pkg::CODE_301 ||
                                 cur.status_chars == hrhp_pkg::CODE_302) begin
                        o_result.status_event = hrhp_pkg::EV_MOVED;
                    end else begin
                        o_result.status_event = hrhp_pkg::EV_OTHER;
                    end
                end
            end
            hrhp_pkg::PH_HEADERS: begin
                if (i_byte == expect_char) begin
                    if (match_inc >= 3'd4) begin
                        o_state.blank_match   = 3'd0;
                        o_state.phase         = hrhp_pkg::PH_BODY;
                        o_result.status_event = hrhp_pkg::EV_HDRDONE;
                    end else begin
                        o_state.blank_match = match_inc;
                    end
                end else begin
                    // a cr restarts the match one byte in
                    o_state.blank_match = (i_byte == hrhp_pkg::CHAR_CR) ? 3'd1 : 3'd0;
                end
            end
            hrhp_pkg::PH_BODY: begin
                o_result.byte_class = hrhp_pkg::CLS_BODY;
                o_result.data_byte  = i_byte;
            end
            default: begin
                // discard phase and unused codes
                o_result.byte_class = hrhp_pkg::CLS_DROP;
            end
        endcase
    end

endmodule

@@ hw/rtl/http_response_header_parser_top.sv @@
// http_response_header_parser_top: streaming http response header parser
// depends on hrhp_pkg and hrhp_step
`timescale 1ns / 1ps

// Sorts a received http response stream one byte per word into header,
// body or discarded bytes. A word with the start flag in tuser restarts the
// parser before that byte is taken. The version token and its space are
// skipped, three status characters are collected, and the next byte reports
// the status: 404 not found, 301/302 moved, any other non-200 value other;
// after these every byte is discarded. For 200 the header lines are consumed
// up to the exact sequence cr lf cr lf (the final lf carries the header
// complete event) and all later bytes pass as body. Every input word yields
// exactly one output word. Throughput is one word per cycle: the parser state
// update is a single combinational step into the state register, and one
// output register holds the result; a new word is taken whenever that
// register is empty or being drained in the same cycle.
// Segment boundaries on tlast are copied through and change no state.

module http_response_header_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic [0:0]  i_s_tuser,   // [0] response_start
    input  logic        i_s_tlast,   // segment_end
    // classified byte stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [1:0] byte_class, [9:2] data_byte,
                                     // [12:10] status_event, [15:13] zero
    output logic        o_m_tlast    // segment_last
);

    hrhp_pkg::t_parse_state r_state;
    hrhp_pkg::t_parse_state n_state;
    hrhp_pkg::t_result      n_result;
    hrhp_pkg::t_result      r_result;
    logic                   r_out_valid;
    logic                   r_out_last;
    logic                   in_accept;

    // accept while the output register is free or emptying this cycle
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_accept  = i_s_tvalid && o_s_tready;

    hrhp_step u_step (
        .i_state  (r_state),
        .i_byte   (i_s_tdata),
        .i_start  (i_s_tuser[0]),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hrhp_pkg::STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result   <= n_result;
            r_out_last <= i_s_tlast;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_result.status_event, r_result.data_byte,
                         r_result.byte_class};
    assign o_m_tlast  = r_out_last;

    // a restart word leaves the parser in the version or digit phase
    a_restart_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_s_tuser[0]) |=>
        (r_state.phase == hrhp_pkg::PH_VERSION || r_state.phase == hrhp_pkg::PH_DIGITS))
        else $error("restart did not return parser to start");

    // data byte is zero unless the word is body
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.byte_class != hrhp_pkg::CLS_BODY) |->
        (r_result.data_byte == 8'd0))
        else $error("data byte set on non-body word");

    // status events come with discarded words, header done with a header word
    a_event_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_result.status_event == hrhp_pkg::EV_NOTFOUND ||
                         r_result.status_event == hrhp_pkg::EV_MOVED ||
                         r_result.status_event == hrhp_pkg::EV_OTHER)) |->
        (r_result.byte_class == hrhp_pkg::CLS_DROP))
        else $error("status event on non-discarded word");

    a_hdrdone_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.status_event == hrhp_pkg::EV_HDRDONE) |->
        (r_result.byte_class == hrhp_pkg::CLS_HEADER &&
         r_state.phase == hrhp_pkg::PH_BODY) || !r_out_valid || !$stable(r_state) ||
        r_state.phase != hrhp_pkg::PH_HEADERS)
        else $error("header done event inconsistent with parser phase");

    // blank line match never reaches four while stored
    a_match_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.blank_match <= 3'd3)
        else $error("blank line match out of range");

endmodule

@@ verif/tb.sv @@
// tb: self-checking bench for http_response_header_parser_top
// depends on hrhp_pkg and the parser rtl; byte sorting is predicted in a class
`timescale 1ns / 1ps

module tb;

    localparam int N_WORDS      = 1100;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;

    // one expected output word
    typedef struct packed {
        logic [1:0] cls;
        logic [7:0] data;
        logic [2:0] ev;
        logic       seg;
    } t_sorted;

    // tracks the parse of the received stream and holds the words still due
    class resp_byte_tracker;
        logic [2:0]  phase;
        logic [1:0]  n_digits;
        logic [23:0] code;
        logic [2:0]  crlf_hits;
        t_sorted     sorted_due[$];
        int          n_bad;

        function new();
            restart();
            n_bad = 0;
        endfunction

        function void restart();
            phase     = hrhp_pkg::PH_VERSION;
            n_digits  = 2'd0;
            code      = 24'd0;
            crlf_hits = 3'd0;
        endfunction

        // accepted input word: advance the parse and queue its outcome
        function void take_rx_byte(logic [7:0] b, logic start, logic seg);
            t_sorted    e;
            logic [7:0] want;
            e.cls  = hrhp_pkg::CLS_HEADER;
            e.data = 8'd0;
            e.ev   = hrhp_pkg::EV_NONE;
            e.seg  = seg;
            if (start)
                restart();
            case (phase)
                hrhp_pkg::PH_VERSION: begin
                    if (b == hrhp_pkg::CHAR_SP)
                        phase = hrhp_pkg::PH_DIGITS;
                end
                hrhp_pkg::PH_DIGITS: begin
                    code = {code[15:0], b};
                    if (n_digits >= 2'd2) begin
                        n_digits = 2'd0;
                        phase    = hrhp_pkg::PH_CLASSIFY;
                    end else begin
                        n_digits = n_digits + 2'd1;
                    end
                end
                hrhp_pkg::PH_CLASSIFY: begin
                    // the classifier byte never counts toward cr lf cr lf
                    if (code == hrhp_pkg::CODE_200) begin
                        phase     = hrhp_pkg::PH_HEADERS;
                        crlf_hits = 3'd0;
                    end else begin
                        e.cls = hrhp_pkg::CLS_DROP;
                        if (code == hrhp_pkg::CODE_404)
                            e.ev = hrhp_pkg::EV_NOTFOUND;
                        else if (code == hrhp_pkg::CODE_301 || code == hrhp_pkg::CODE_302)
                            e.ev = hrhp_pkg::EV_MOVED;
                        else
                            e.ev = hrhp_pkg::EV_OTHER;
                        phase = hrhp_pkg::PH_DISCARD;
                    end
                end
                hrhp_pkg::PH_HEADERS: begin
                    // even match count waits for cr, odd for lf
                    want = crlf_hits[0] ? hrhp_pkg::CHAR_LF : hrhp_pkg::CHAR_CR;
                    if (b == want)
                        crlf_hits = crlf_hits + 3'd1;
                    else
                        crlf_hits = (b == hrhp_pkg::CHAR_CR) ? 3'd1 : 3'd0;
                    if (crlf_hits >= 3'd4) begin
                        crlf_hits = 3'd0;
                        e.ev      = hrhp_pkg::EV_HDRDONE;
                        phase     = hrhp_pkg::PH_BODY;
                    end
                end
                hrhp_pkg::PH_BODY: begin
                    e.cls  = hrhp_pkg::CLS_BODY;
                    e.data = b;
                end
                default: begin
                    e.cls = hrhp_pkg::CLS_DROP;
                end
            endcase
            sorted_due.push_back(e);
        endfunction

        // accepted output word: compare with the oldest outcome due
        function void match_sorted_word(logic [15:0] w, logic last);
            t_sorted e;
            if (sorted_due.size() == 0) begin
                $display("%0t: output word %h with nothing expected", $time, w);
                n_bad++;
                return;
            end
            e = sorted_due.pop_front();
            if (w[1:0] !== e.cls) begin
                $display("%0t: byte_class expected %0d actual %0d", $time, e.cls, w[1:0]);
                n_bad++;
            end
            if (w[9:2] !== e.data) begin
                $display("%0t: data_byte expected %h actual %h", $time, e.data, w[9:2]);
                n_bad++;
            end
            if (w[12:10] !== e.ev) begin
                $display("%0t: status_event expected %0d actual %0d",
                         $time, e.ev, w[12:10]);
                n_bad++;
            end
            if (w[15:13] !== 3'd0) begin
                $display("%0t: pad bits expected 0 actual %b", $time, w[15:13]);
                n_bad++;
            end
            if (last !== e.seg) begin
                $display("%0t: segment_last expected %b actual %b", $time, e.seg, last);
                n_bad++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] rx_byte
    logic [0:0]  i_s_tuser;   // [0] response_start
    logic        i_s_tlast;   // segment_end
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [1:0] byte_class, [9:2] data_byte,
                              // [12:10] status_event, [15:13] zero
    logic        o_m_tlast;   // segment_last

    resp_byte_tracker trk;
    int               n_sent;
    int               n_cycles;
    logic             quiet;       // no idling on either side while set
    logic             stall_req;   // asks the receiver for one long hold-off
    logic             stall_done;

    http_response_header_parser_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watch both handshakes; input side first so the queue is never short
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                trk.take_rx_byte(i_s_tdata, i_s_tuser[0], i_s_tlast);
            if (o_m_tvalid && i_m_tready)
                trk.match_sorted_word(o_m_tdata, o_m_tlast);
        end
    end

    // receiver: random stalls plus one long hold-off to back up the input
    initial begin
        int hold_left;
        hold_left  = 0;
        stall_done = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req && !stall_done) begin
                hold_left  = HOLD_CYCLES;
                stall_done = 1'b1;
            end
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_tready <= quiet || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    // run limit
    initial begin
        n_cycles = 0;
        while (n_cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            n_cycles++;
        end
        $display("http_response_header_parser_top test failed");
        $finish;
    end

    // offer one word and hold it until taken
    task automatic send_word(input logic [7:0] b, input logic st, input logic lst);
        while (!quiet && $urandom_range(0, 99) < 11) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid   <= 1'b1;
        i_s_tdata    <= b;
        i_s_tuser[0] <= st;
        i_s_tlast    <= lst;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        n_sent++;
    endtask

    task automatic send_text(input string s, input logic st);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], st && (i == 0), 1'b0);
    endtask

    // printable character, never cr, lf or space
    function automatic logic [7:0] text_char();
        return 8'($urandom_range(33, 126));
    endfunction

    // a mostly well-formed response with random content
    task automatic send_response();
        logic [7:0]  q[$];
        logic [7:0]  c;
        logic [23:0] code;
        int          n;
        int          pick;
        n = $urandom_range(0, 4);
        repeat (n) begin
            c = 8'($urandom);
            q.push_back((c == hrhp_pkg::CHAR_SP) ? 8'h48 : c);
        end
        q.push_back(hrhp_pkg::CHAR_SP);
        pick = $urandom_range(0, 9);
        case (pick)
            4:       code = hrhp_pkg::CODE_404;
            5:       code = hrhp_pkg::CODE_301;
            6:       code = hrhp_pkg::CODE_302;
            7:       code = {16'h3230, 8'h30 + 8'($urandom_range(0, 9))};
            8:       code = 24'($urandom);
            9:       code = {16'h3330, 8'h30 + 8'($urandom_range(0, 9))};
            default: code = hrhp_pkg::CODE_200;
        endcase
        q.push_back(code[23:16]);
        q.push_back(code[15:8]);
        q.push_back(code[7:0]);
        q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : hrhp_pkg::CHAR_SP);
        if (code == hrhp_pkg::CODE_200) begin
            // reason phrase, header lines, then the blank line
            repeat ($urandom_range(0, 4)) q.push_back(text_char());
            q.push_back(hrhp_pkg::CHAR_CR);
            q.push_back(hrhp_pkg::CHAR_LF);
            repeat ($urandom_range(0, 3)) begin
                repeat ($urandom_range(0, 6)) q.push_back(text_char());
                if ($urandom_range(0, 6) == 0)
                    q.push_back($urandom_range(0, 1) ? hrhp_pkg::CHAR_CR
                                                     : hrhp_pkg::CHAR_LF);
                q.push_back(hrhp_pkg::CHAR_CR);
                q.push_back(hrhp_pkg::CHAR_LF);
            end
            q.push_back(hrhp_pkg::CHAR_CR);
            q.push_back(hrhp_pkg::CHAR_LF);
            repeat ($urandom_range(0, 12)) q.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 6)) q.push_back(8'($urandom));
        end
        // sometimes cut short so the next start lands mid-response
        if ($urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, q.size());
            while (q.size() > n)
                void'(q.pop_back());
        end
        for (int i = 0; i < q.size(); i++)
            send_word(q[i], i == 0, $urandom_range(0, 4) == 0);
    endtask

    // raw bytes with random start and segment flags
    task automatic send_noise();
        repeat ($urandom_range(1, 10))
            send_word(8'($urandom), $urandom_range(0, 9) < 3, $urandom_range(0, 1));
    endtask

    initial begin
        trk        = new();
        n_sent     = 0;
        quiet      = 1'b0;
        stall_req  = 1'b0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'd0;
        i_s_tuser  = 1'b0;
        i_s_tlast  = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 200 with a version token, cr as classifier, a broken terminator,
        // then body bytes at both extremes
        send_text("H 200\015\n\015\015\n\015\n", 1'b1);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        // restart in the middle of the status digits, then not found
        send_text(" 4", 1'b1);
        send_text(" 404xy", 1'b1);
        // another status
        send_text(" 500 ", 1'b1);

        while (n_sent < N_WORDS) begin
            if (n_sent >= 300)
                stall_req = 1'b1;
            quiet = (n_sent >= 600) && (n_sent < 800);
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_response();
        end
        i_s_tvalid <= 1'b0;
        quiet = 1'b0;

        // let the last accepted word reach the tracker before draining
        @(posedge i_clk);
        while (trk.sorted_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (trk.n_bad == 0)
            $display("http_response_header_parser_top test passed");
        else
            $display("http_response_header_parser_top test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/hrhp_pkg.sv
hw/rtl/hrhp_step.sv
hw/rtl/http_response_header_parser_top.sv
verif/tb.sv
